// ----- hdl/fbpf_pkg.sv -----
// ----------------------------------------------------------------------------
// fbpf_pkg
// Shared types, constants and functions of the firmware block packet framer.
// ----------------------------------------------------------------------------
package fbpf_pkg;

  localparam int PAYLOAD_BYTES_DEF = 256;
  localparam int LEAD_BYTES        = 7;   // fixed preamble bytes
  localparam int HEAD_BYTES        = 11;  // preamble, 3 offset bytes, crc byte
  localparam int OFF_W             = 24;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP  = 2'd2;

  localparam logic             SKIP_RESET  = 1'b1;
  localparam logic [OFF_W-1:0] START_RESET = 24'h003000;
  localparam logic [OFF_W-1:0] STOP_RESET  = 24'h008000;

  localparam logic [7:0] PAD_BYTE = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h8C;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_PAD,
    ST_CLOSE,
    ST_EMIT,
    ST_DRAIN
  } fbpf_state_t;

  typedef struct packed {
    logic clear;
    logic feed;
  } crc_ctl_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } emit_req_t;

  typedef struct packed {
    logic byte_ready;
    logic idle;
  } emit_stat_t;

  function automatic logic [7:0] lead_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h02;
      3'd1:    b = 8'h00;
      3'd2:    b = 8'h0F;
      3'd3:    b = 8'h06;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h08;
      3'd6:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // one byte of CRC-8/MAXIM, input byte bit-reversed first
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] x;
    for (int i = 0; i < 8; i++) begin
      x[7-i] = d[i];
    end
    x = x ^ crc;
    for (int i = 0; i < 8; i++) begin
      if (x[0]) begin
        x = (x >> 1) ^ CRC_POLY;
      end else begin
        x = x >> 1;
      end
    end
    return x;
  endfunction

endpackage

// ----- hdl/fbpf_in_if.sv -----
// ----------------------------------------------------------------------------
// fbpf_in_if
// Image byte request channel.
// ----------------------------------------------------------------------------
interface fbpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// ----- hdl/fbpf_out_if.sv -----
// ----------------------------------------------------------------------------
// fbpf_out_if
// Packet word request channel.
// ----------------------------------------------------------------------------
interface fbpf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] packet_word;
  logic [3:0]  valid_bytes;
  logic [23:0] block_offset;
  logic        end_of_packet;

  modport source (output valid, output packet_word, output valid_bytes,
                  output block_offset, output end_of_packet, input ready);
  modport sink   (input valid, input packet_word, input valid_bytes,
                  input block_offset, input end_of_packet, output ready);
endinterface

// ----- hdl/fbpf_cfg_if.sv -----
// ----------------------------------------------------------------------------
// fbpf_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
interface fbpf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/fbpf_crc_unit.sv -----
// ----------------------------------------------------------------------------
// fbpf_crc_unit
// Shared CRC-8 byte unit with its running register.
// ----------------------------------------------------------------------------
module fbpf_crc_unit import fbpf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  crc_ctl_t   ctl,
  input  logic [7:0] data,
  output logic [7:0] crc
);

  logic [7:0] crc_reg;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      crc_reg <= 8'h00;
    end else if (ctl.feed) begin
      crc_reg <= crc8_feed(crc_reg, data);
    end
  end

  assign crc = crc_reg;

endmodule

// ----- hdl/fbpf_block_mem.sv -----
// ----------------------------------------------------------------------------
// fbpf_block_mem
// Block buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fbpf_block_mem import fbpf_pkg::*; #(
  parameter int DEPTH = PAYLOAD_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/fbpf_emitter.sv -----
// ----------------------------------------------------------------------------
// fbpf_emitter
// Packs packet bytes into big-endian words and holds them in the output
// register.
// ----------------------------------------------------------------------------
module fbpf_emitter import fbpf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  emit_req_t         req,
  input  logic [OFF_W-1:0]  offset,
  output emit_stat_t        stat,
  fbpf_out_if.source        dout
);

  logic [63:0]      asm_word;
  logic [3:0]       asm_cnt;
  logic             asm_done;
  logic             asm_full;
  logic             move;
  logic             take;

  logic             out_valid;
  logic [63:0]      out_word;
  logic [3:0]       out_cnt;
  logic [OFF_W-1:0] out_off;
  logic             out_eop;

  always_comb begin
    asm_full        = (asm_cnt == 4'd8) || asm_done;
    move            = asm_full && (!out_valid || dout.ready);
    take            = req.valid && !asm_full;
    stat.byte_ready = !asm_full;
    stat.idle       = (asm_cnt == 4'd0) && !asm_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      asm_cnt   <= 4'd0;
      asm_done  <= 1'b0;
      asm_word  <= 64'd0;
      out_valid <= 1'b0;
    end else begin
      if (move) begin
        asm_cnt  <= 4'd0;
        asm_done <= 1'b0;
        asm_word <= 64'd0;
      end else if (take) begin
        asm_cnt  <= asm_cnt + 4'd1;
        asm_done <= req.last;
        asm_word[{3'd7 - asm_cnt[2:0], 3'b000} +: 8] <= req.data;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_word <= asm_word;
      out_cnt  <= asm_cnt;
      out_off  <= offset;
      out_eop  <= asm_done;
    end
  end

  assign dout.valid         = out_valid;
  assign dout.packet_word   = out_word;
  assign dout.valid_bytes   = out_cnt;
  assign dout.block_offset  = out_off;
  assign dout.end_of_packet = out_eop;

endmodule

// ----- hdl/firmware_block_packet_framer.sv -----
// ----------------------------------------------------------------------------
// firmware_block_packet_framer
// Gathers image bytes into blocks, pads, computes a CRC-8 and frames each
// kept block as a packet of 64-bit words.
// ----------------------------------------------------------------------------
// Input: one byte per cycle while a block fills; ready drops from the byte
//   that closes a block until it is dropped or its packet's last word has left the assembler.
// Reset: synchronous; clears counters, offset, CRC, output valid; config to 1/0x3000/0x8000.
module firmware_block_packet_framer import fbpf_pkg::*; #(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  fbpf_in_if.sink     din,
  fbpf_out_if.source  dout,
  fbpf_cfg_if.sink    cfg
);

  localparam int PKT_BYTES = HEAD_BYTES + PAYLOAD_BYTES;
  localparam int AW        = $clog2(PAYLOAD_BYTES);
  localparam int CW        = $clog2(PAYLOAD_BYTES + 1);
  localparam int PW        = $clog2(PKT_BYTES);

  // config registers
  logic             skip_user_area;
  logic [OFF_W-1:0] user_area_start;
  logic [OFF_W-1:0] user_area_stop;

  // sequencer state
  fbpf_state_t      state, state_next;
  logic [CW-1:0]    fill, fill_next;
  logic [PW-1:0]    pos, pos_next;
  logic [OFF_W-1:0] offset, offset_next;
  logic             last_seen, last_seen_next;

  logic             accept;
  logic             drop;
  logic [CW-1:0]    fill_inc;
  logic [PW-1:0]    data_pos;

  // block memory
  logic             mem_we;
  logic [7:0]       mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [7:0]       mem_rdata;

  crc_ctl_t         crc_ctl;
  logic [7:0]       crc;
  emit_req_t        emit_req;
  emit_stat_t       emit_stat;

  // --------------------------------------------------------------------------
  // Configuration writes; unknown index ignored.
  // --------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_user_area  <= SKIP_RESET;
      user_area_start <= START_RESET;
      user_area_stop  <= STOP_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SKIP:  skip_user_area  <= cfg.data[0];
        CFG_START: user_area_start <= cfg.data;
        CFG_STOP:  user_area_stop  <= cfg.data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      fill      <= '0;
      pos       <= '0;
      offset    <= '0;
      last_seen <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      pos       <= pos_next;
      offset    <= offset_next;
      last_seen <= last_seen_next;
    end
  end

  assign din.ready = (state == ST_FILL);

  always_comb begin
    accept   = din.valid && din.ready;
    fill_inc = CW'(fill + 1'b1);
    // drop only when the area is a real range that holds this offset
    drop     = skip_user_area && (offset >= user_area_start) && (offset < user_area_stop);

    state_next     = state;
    fill_next      = fill;
    pos_next       = pos;
    offset_next    = offset;
    last_seen_next = last_seen;

    mem_we         = 1'b0;
    mem_wdata      = PAD_BYTE;
    crc_ctl        = '0;
    emit_req       = '0;

    unique case (state)
      ST_FILL: begin
        if (accept) begin
          mem_we         = 1'b1;
          mem_wdata      = din.in_byte;
          crc_ctl.feed   = 1'b1;
          fill_next      = fill_inc;
          last_seen_next = din.last_byte;
          if (fill_inc == CW'(PAYLOAD_BYTES)) begin
            state_next = ST_CLOSE;
          end else if (din.last_byte) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // short block: fill with 0xFF, CRC runs over the padding too
        mem_we       = 1'b1;
        crc_ctl.feed = 1'b1;
        fill_next    = fill_inc;
        if (fill_inc == CW'(PAYLOAD_BYTES)) begin
          state_next = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        fill_next = '0;
        pos_next  = '0;
        if (drop) begin
          crc_ctl.clear  = 1'b1;
          offset_next    = last_seen ? '0 : offset + OFF_W'(PAYLOAD_BYTES);
          last_seen_next = 1'b0;
          state_next     = ST_FILL;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        emit_req.valid = 1'b1;
        emit_req.last  = (pos == PW'(PKT_BYTES - 1));
        priority if (pos < PW'(LEAD_BYTES)) begin
          emit_req.data = lead_byte(pos[2:0]);
        end else if (pos == PW'(LEAD_BYTES)) begin
          emit_req.data = offset[23:16];
        end else if (pos == PW'(LEAD_BYTES + 1)) begin
          emit_req.data = offset[15:8];
        end else if (pos == PW'(LEAD_BYTES + 2)) begin
          emit_req.data = offset[7:0];
        end else if (pos == PW'(HEAD_BYTES - 1)) begin
          emit_req.data = crc;
        end else begin
          emit_req.data = mem_rdata;
        end
        if (emit_stat.byte_ready) begin
          if (emit_req.last) begin
            pos_next   = '0;
            state_next = ST_DRAIN;
          end else begin
            pos_next = PW'(pos + 1'b1);
          end
        end
      end
      ST_DRAIN: begin
        // offset stays put until the final word has its copy
        if (emit_stat.idle) begin
          crc_ctl.clear  = 1'b1;
          offset_next    = last_seen ? '0 : offset + OFF_W'(PAYLOAD_BYTES);
          last_seen_next = 1'b0;
          state_next     = ST_FILL;
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase

    // read one byte ahead so the registered data lines up with pos
    data_pos = PW'(pos_next - PW'(HEAD_BYTES));
    if ((pos_next >= PW'(HEAD_BYTES)) && (data_pos < PW'(PAYLOAD_BYTES))) begin
      mem_raddr = data_pos[AW-1:0];
    end else begin
      mem_raddr = '0;
    end
  end

  fbpf_block_mem #(
    .DEPTH (PAYLOAD_BYTES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (fill[AW-1:0]),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fbpf_crc_unit u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (crc_ctl),
    .data (mem_wdata),
    .crc  (crc)
  );

  fbpf_emitter u_emit (
    .clk    (clk),
    .rst    (rst),
    .req    (emit_req),
    .offset (offset),
    .stat   (emit_stat),
    .dout   (dout)
  );

endmodule

// ----- verif/tb_firmware_block_packet_framer.sv -----
// ----------------------------------------------------------------------------
// tb_firmware_block_packet_framer
// Self-checking bench for the block packet framer. Image bytes go in as
// requests on the input channel; a software copy of the framer rebuilds the
// padded block, its bit-reversed CRC-8 and the framed packet words, which
// are compared field by field with every word the block emits. The user
// area registers are reprogrammed between phases, with idle gaps on both
// channels and long output stalls.
// ----------------------------------------------------------------------------
module tb_firmware_block_packet_framer;
  import fbpf_pkg::*;

  localparam int PB        = PAYLOAD_BYTES_DEF;
  localparam int PKT_BYTES = HEAD_BYTES + PB;
  localparam int PKT_WORDS = (PKT_BYTES + 7) / 8;

  // fixed packet lead-in, first byte in the top bits
  localparam logic [55:0] PREAMBLE = 56'h02_00_0F_06_01_08_01;

  // index with no register behind it; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // A dropped block gives no words but keeps the block busy padding, so
  // config writes wait SETTLE_CYCLES after the last word.
  localparam int SETTLE_CYCLES  = 2 * (PB + 9 * PKT_WORDS + 3);
  localparam int RX_HOLD_CYCLES = 1500;
  // Worst case every byte ends an image with its own packet, plus settle
  // gaps and holds; the limit leaves a wide margin over that.
  localparam int LIMIT_CYCLES   = 5000000;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic [23:0] offset;
    logic        eop;
  } pkt_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fbpf_in_if  in_ch ();
  fbpf_out_if out_ch ();
  fbpf_cfg_if cfg_ch ();

  firmware_block_packet_framer #(
    .PAYLOAD_BYTES(PB)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .din  (in_ch),
    .dout (out_ch),
    .cfg  (cfg_ch)
  );

  // --------------------------------------------------------------------------
  // Framer model state: open block, its offset and running CRC, user area.
  // --------------------------------------------------------------------------
  logic [7:0]  blk_mem [PB];
  int unsigned blk_fill;
  logic [23:0] blk_off;
  logic [7:0]  blk_crc;
  logic        area_skip;
  logic [23:0] area_start;
  logic [23:0] area_stop;

  pkt_word_t   pkt_q [$];   // packet words still owed by the block
  pkt_word_t   want_w;

  int errors;
  int bytes_sent;
  int words_checked;
  int packets_checked;
  int blocks_dropped;
  int stall_cycles;
  int cycle_count;

  // traffic shaping
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_req;
  int rx_hold_seen;
  int rx_hold_left;

  // CRC-8/MAXIM step, data byte mirrored before it goes in
  function automatic logic [7:0] crc8_mirrored(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] x;
    for (int i = 0; i < 8; i++) begin
      x[i] = d[7-i];
    end
    x = x ^ crc;
    repeat (8) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  // One accepted image byte. On block close: pad, then either drop the
  // block or queue every word of its packet.
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    pkt_word_t w;
    logic [7:0] pb;
    int pos;
    blk_mem[blk_fill] = b;
    blk_crc = crc8_mirrored(blk_crc, b);
    blk_fill++;
    if (blk_fill < PB && !last) return;
    // short final block: fill up with pad bytes, which also go into the CRC
    while (blk_fill < PB) begin
      blk_mem[blk_fill] = PAD_BYTE;
      blk_crc = crc8_mirrored(blk_crc, PAD_BYTE);
      blk_fill++;
    end
    if (area_skip && blk_off >= area_start && blk_off < area_stop) begin
      blocks_dropped++;
    end else begin
      for (int i = 0; i < PKT_WORDS; i++) begin
        w = '0;
        w.offset = blk_off;
        w.eop = (i == PKT_WORDS - 1);
        for (int k = 0; k < 8; k++) begin
          pos = i * 8 + k;
          if (pos < PKT_BYTES) begin
            if (pos < LEAD_BYTES)          pb = PREAMBLE[55 - 8 * pos -: 8];
            else if (pos == LEAD_BYTES)     pb = blk_off[23:16];
            else if (pos == LEAD_BYTES + 1) pb = blk_off[15:8];
            else if (pos == LEAD_BYTES + 2) pb = blk_off[7:0];
            else if (pos == LEAD_BYTES + 3) pb = blk_crc;
            else                            pb = blk_mem[pos - HEAD_BYTES];
            w.word[63 - 8 * k -: 8] = pb;
            w.nbytes = w.nbytes + 4'd1;
          end
        end
        pkt_q.push_back(w);
      end
    end
    blk_fill = 0;
    blk_crc = '0;
    // a new image starts at offset 0; otherwise step one block, 24-bit wrap
    blk_off = last ? 24'h0 : blk_off + PB[23:0];
  endtask

  // Model update on every accepted config write and image byte request.
  always @(posedge clk) begin
    if (rst) begin
      blk_fill = 0;
      blk_off = '0;
      blk_crc = '0;
      area_skip = SKIP_RESET;
      area_start = START_RESET;
      area_stop = STOP_RESET;
      pkt_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_SKIP:  area_skip = cfg_ch.data[0];
          CFG_START: area_start = cfg_ch.data;
          CFG_STOP:  area_stop = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        bytes_sent++;
        absorb_byte(in_ch.in_byte, in_ch.last_byte);
      end
      if (in_ch.valid && !in_ch.ready) stall_cycles++;
    end
  end

  // --------------------------------------------------------------------------
  // Word checker: every accepted output word against the oldest owed word.
  // --------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pkt_q.size() == 0) begin
        $display("%0t: unexpected packet word, expected none, got %h (offset %h)",
                 $time, out_ch.packet_word, out_ch.block_offset);
        errors++;
      end else begin
        want_w = pkt_q.pop_front();
        check_field("packet_word", want_w.word, out_ch.packet_word);
        check_field("valid_bytes", 64'(want_w.nbytes), 64'(out_ch.valid_bytes));
        check_field("block_offset", 64'(want_w.offset), 64'(out_ch.block_offset));
        check_field("end_of_packet", 64'(want_w.eop), 64'(out_ch.end_of_packet));
        words_checked++;
        if (want_w.eop) packets_checked++;
      end
    end
  end

  // Receiver: random ready, or a long hold-off when the test asks for one.
  always @(posedge clk) begin
    if (rx_hold_seen != rx_hold_req) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= RX_HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d packet words outstanding", $time, pkt_q.size());
      $display("firmware_block_packet_framer test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // One image byte request; valid is left high so back-to-back bytes
  // need no second assignment in the same step.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_image(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
  endtask

  // always waits for the clock before it first checks the queue
  task automatic wait_drained();
    @(posedge clk);
    while (pkt_q.size() != 0) @(posedge clk);
  endtask

  // block idle: nothing owed and any dropped block done padding
  task automatic quiesce();
    stop_sending();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // All three area registers, then a random write to the unused index,
  // which must leave them untouched. Upper bits of the skip data are noise.
  task automatic program_area(input logic [23:0] skip_data, input logic [23:0] start,
                              input logic [23:0] stop);
    write_reg(CFG_SKIP, skip_data);
    write_reg(CFG_START, start);
    write_reg(CFG_STOP, stop);
    write_reg(CFG_SPARE, 24'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset area settings: single-byte images of the extremes, 8-byte images of
  // walking ones and zeros, a 2-byte one; each a heavily padded block at offset 0.
  task automatic test_directed_images();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    for (int i = 0; i < 8; i++) send_byte(8'h01 << i, i == 7);
    for (int i = 0; i < 8; i++) send_byte(~(8'h01 << i), i == 7);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  // Drop decision at offset 0 across area edges, empty and inverted areas,
  // skip masking, and the unused register index.
  task automatic test_user_area();
    quiesce();
    program_area(24'hFFFFFF, 24'h000000, 24'h000001);  // offset 0 inside: dropped
    send_image($urandom_range(1, 6));
    send_image($urandom_range(1, 6));
    quiesce();
    program_area(24'h000001, 24'h000001, 24'hFFFFFF);  // below start: kept
    send_image($urandom_range(1, 6));
    quiesce();
    program_area(24'h000001, 24'hFFFFFF, 24'h000000);  // inverted: kept
    send_image($urandom_range(1, 6));
    quiesce();
    program_area(24'h000001, 24'h000000, 24'h000000);  // empty: kept
    send_image($urandom_range(1, 6));
    quiesce();
    program_area(24'hFFFFFE, 24'h000000, 24'hFFFFFF);  // skip bit clear: kept
    send_image($urandom_range(1, 6));
  endtask

  // Two-block image: the first block closes on its byte count and is
  // dropped while the offset still steps; the second closes full and last
  // at once and goes out at the next block offset.
  task automatic test_full_blocks();
    quiesce();
    program_area(24'h000001, 24'h000000, 24'h000100);  // only block 0 dropped
    send_image(2 * PB);
  endtask

  // Mostly very short images, some medium ones, random area settings every
  // few images, with occasional pauses until the block has caught up.
  task automatic test_random_images(input int budget);
    int sent;
    int left;
    int len;
    int r;
    sent = 0;
    left = 0;
    while (sent < budget) begin
      if (left == 0) begin
        quiesce();
        case ($urandom_range(3))
          0: program_area(24'($urandom | 1), 24'h000000,
                          24'($urandom_range(1, 24'hFFFFFF)));
          1: program_area(24'($urandom), 24'($urandom), 24'($urandom));
          2: program_area(24'($urandom | 1), 24'h000100, 24'h000200);
          default: program_area(24'(SKIP_RESET), START_RESET, STOP_RESET);
        endcase
        left = $urandom_range(3, 6);
      end
      r = $urandom_range(99);
      len = (r < 85) ? $urandom_range(1, 12) : $urandom_range(13, 48);
      send_image(len);
      sent += len;
      left--;
      if ($urandom_range(4) == 0) begin
        stop_sending();
        wait_drained();
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering images, so the
  // packet backs up and the input side stalls.
  task automatic test_output_stall();
    quiesce();
    program_area(24'h000000, 24'h000000, 24'h000000);
    rx_hold_req++;
    for (int i = 0; i < 3; i++) send_image($urandom_range(1, 20));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.last_byte <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_SKIP;
    cfg_ch.data <= '0;
    tx_idle_pct = 31;
    rx_idle_pct = 76;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender idles rarely, receiver often
    test_directed_images();
    test_user_area();
    test_random_images(12);

    // the other way round
    tx_idle_pct = 76;
    rx_idle_pct = 31;
    test_full_blocks();
    test_random_images(12);

    // full rate both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_images(12);
    test_output_stall();

    quiesce();
    $display("Sent %0d image bytes (short, padded, full and multi-block images);",
             bytes_sent);
    $display("checked %0d packets / %0d words, %0d blocks dropped, input stalled %0d cycles.",
             packets_checked, words_checked, blocks_dropped, stall_cycles);
    if (errors == 0) begin
      $display("firmware_block_packet_framer test passed");
    end else begin
      $display("firmware_block_packet_framer test failed");
    end
    $finish;
  end

endmodule
